// ----- rtl/column_perfect_square_finder_core_macros.svh -----
// ----------------------------------------------------------------------------
// column perfect square finder assertion macros
// shared concurrent assertion forms, clocked and held off during reset
// ----------------------------------------------------------------------------
`ifndef COLUMN_PERFECT_SQUARE_FINDER_CORE_MACROS_SVH
`define COLUMN_PERFECT_SQUARE_FINDER_CORE_MACROS_SVH

// same-cycle implication
`define CPSF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("cpsf assertion failed");

// next-cycle implication
`define CPSF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("cpsf assertion failed");

`endif

// ----- rtl/cpsf_pkg.sv -----
// ----------------------------------------------------------------------------
// cpsf_pkg
// shared constants and types of the column perfect square finder
// ----------------------------------------------------------------------------
package cpsf_pkg;

	localparam int MAX_COLUMNS = 64;
	localparam int COL_W       = 6;
	localparam int COUNT_W     = 7;
	localparam int VALUE_W     = 32;
	localparam int ROOT_W      = VALUE_W / 2;
	localparam int REM_W       = ROOT_W + 1;
	localparam int ROOT_STEPS  = VALUE_W / 2;
	localparam int STEP_W      = 4;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 8;

	localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROOT,
		ST_CHECK,
		ST_SCAN
	} state_t;

endpackage

// ----- rtl/column_perfect_square_finder_core.sv -----
// ----------------------------------------------------------------------------
// column_perfect_square_finder_core
// elements come in on the s_ stream with their column and a last mark; each is
// tested for being a perfect square by an exact integer square root, two bits
// per cycle, and the hit is ORed into a per-column flag. on the last element
// the flagged columns below column_count go out on the m_ stream in ascending
// order, the final one with m_tlast, or one transfer with m_tuser set when none
// is flagged; the flags are then empty again.
// an element is taken in the accept cycle, then runs 16 root iterations of the
// shared two-bit remainder unit; a last element then has a check state and, if
// any column is flagged, a scan up to the highest flagged one. the result sits
// in an output register, so a new element is taken while a result still waits;
// the column scan only pauses while the receiver stalls. reset clears the flags,
// the output valid and sets column_count to 64. the user must write column_count
// via cfg_we/cfg_wdata only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`include "column_perfect_square_finder_core_macros.svh"

module column_perfect_square_finder_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [cpsf_pkg::COUNT_W-1:0]          cfg_wdata,    // column_count
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [cpsf_pkg::IN_TDATA_W-1:0]       s_tdata,      // element_value, column_index
	input  logic                                  s_tlast,      // last_element
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [cpsf_pkg::OUT_TDATA_W-1:0]      m_tdata,      // found_column
	output logic                                  m_tuser,      // none_found
	output logic                                  m_tlast       // last_of_run
);

	cpsf_pkg::state_t state_q, state_d;

	logic [cpsf_pkg::COUNT_W-1:0]     col_count_q;
	logic [cpsf_pkg::VALUE_W-1:0]     val_q;
	logic [cpsf_pkg::REM_W-1:0]       rem_q;
	logic [cpsf_pkg::ROOT_W-1:0]      root_q;
	logic [cpsf_pkg::STEP_W-1:0]      cnt_q;
	logic                             neg_q;
	logic                             last_q;
	logic [cpsf_pkg::COL_W-1:0]       col_q;
	logic [cpsf_pkg::MAX_COLUMNS-1:0] flags_q;
	logic [cpsf_pkg::COL_W-1:0]       scan_q;

	logic                             out_valid_q;
	logic [cpsf_pkg::COL_W-1:0]       out_col_q;
	logic                             out_none_q;
	logic                             out_last_q;

	logic [cpsf_pkg::REM_W+1:0]       rem_sh;
	logic [cpsf_pkg::REM_W+1:0]       trial;
	logic                             ge;
	logic [cpsf_pkg::REM_W-1:0]       rem_next;
	logic                             root_done;
	logic                             square;
	logic [cpsf_pkg::MAX_COLUMNS-1:0] flags_hit;
	logic [cpsf_pkg::MAX_COLUMNS-1:0] lim_mask;
	logic                             out_free;
	logic                             scan_step;
	logic                             load_out;
	logic [cpsf_pkg::COL_W-1:0]       out_col_d;
	logic                             out_none_d;
	logic                             out_last_d;

	// one remainder step: bring down two bits, try to subtract 4*root+1
	assign rem_sh    = {rem_q, val_q[cpsf_pkg::VALUE_W-1 -: 2]};
	assign trial     = {1'b0, root_q, 2'b01};
	assign ge        = (rem_sh >= trial);
	assign rem_next  = ge ? cpsf_pkg::REM_W'(rem_sh - trial) : cpsf_pkg::REM_W'(rem_sh);
	assign root_done = (cnt_q == cpsf_pkg::STEP_W'(cpsf_pkg::ROOT_STEPS - 1));

	// zero remainder after the last step means an exact root
	assign square    = !neg_q && (rem_next == '0);
	assign flags_hit = flags_q |
		(square ? (cpsf_pkg::MAX_COLUMNS'(1) << col_q) : '0);

	always_comb begin
		for (int i = 0; i < cpsf_pkg::MAX_COLUMNS; i++) begin
			lim_mask[i] = (cpsf_pkg::COUNT_W'(i) < col_count_q);
		end
	end

	assign out_free  = !out_valid_q || m_tready;
	assign scan_step = (state_q == cpsf_pkg::ST_SCAN) && (!flags_q[0] || out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cpsf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		load_out   = 1'b0;
		out_col_d  = scan_q;
		out_none_d = 1'b0;
		out_last_d = 1'b0;
		unique case (state_q)
			cpsf_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = cpsf_pkg::ST_ROOT;
				end
			end
			cpsf_pkg::ST_ROOT: begin
				if (root_done) begin
					state_d = last_q ? cpsf_pkg::ST_CHECK : cpsf_pkg::ST_IDLE;
				end
			end
			cpsf_pkg::ST_CHECK: begin
				if (flags_q == '0) begin
					if (out_free) begin
						load_out   = 1'b1;
						out_col_d  = '0;
						out_none_d = 1'b1;
						out_last_d = 1'b1;
						state_d    = cpsf_pkg::ST_IDLE;
					end
				end else begin
					state_d = cpsf_pkg::ST_SCAN;
				end
			end
			cpsf_pkg::ST_SCAN: begin
				if (flags_q[0] && out_free) begin
					load_out   = 1'b1;
					// nothing flagged above this column ends the listing
					out_last_d = (flags_q[cpsf_pkg::MAX_COLUMNS-1:1] == '0);
					if (out_last_d) begin
						state_d = cpsf_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = cpsf_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_count_q <= cpsf_pkg::COUNT_RESET;
			flags_q     <= '0;
			scan_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				col_count_q <= cfg_wdata;
			end
			if (state_q == cpsf_pkg::ST_IDLE && s_tvalid) begin
				cnt_q <= '0;
			end else if (state_q == cpsf_pkg::ST_ROOT) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (state_q == cpsf_pkg::ST_ROOT && root_done) begin
				flags_q <= last_q ? (flags_hit & lim_mask) : flags_hit;
				scan_q  <= '0;
			end else if (scan_step) begin
				flags_q <= flags_q >> 1;
				scan_q  <= scan_q + 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == cpsf_pkg::ST_IDLE && s_tvalid) begin
			val_q  <= s_tdata[cpsf_pkg::VALUE_W-1:0];
			neg_q  <= s_tdata[cpsf_pkg::VALUE_W-1];
			col_q  <= s_tdata[cpsf_pkg::VALUE_W +: cpsf_pkg::COL_W];
			last_q <= s_tlast;
			rem_q  <= '0;
			root_q <= '0;
		end else if (state_q == cpsf_pkg::ST_ROOT) begin
			val_q  <= val_q << 2;
			rem_q  <= rem_next;
			root_q <= {root_q[cpsf_pkg::ROOT_W-2:0], ge};
		end
		if (load_out) begin
			out_col_q  <= out_col_d;
			out_none_q <= out_none_d;
			out_last_q <= out_last_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(cpsf_pkg::OUT_TDATA_W - cpsf_pkg::COL_W){1'b0}}, out_col_q};
	assign m_tuser  = out_none_q;
	assign m_tlast  = out_last_q;

	`CPSF_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready, !s_tready)
	`CPSF_ASSERT_IMPL(a_scan_has_flags, clk, arst_n, state_q == cpsf_pkg::ST_SCAN, flags_q != '0)
	`CPSF_ASSERT_NEXT(a_flags_empty_after_list, clk, arst_n,
		state_q == cpsf_pkg::ST_SCAN && state_d == cpsf_pkg::ST_IDLE, flags_q == '0)
	`CPSF_ASSERT_IMPL(a_none_is_single, clk, arst_n, m_tvalid && m_tuser,
		m_tlast && m_tdata == '0)

endmodule
